// ----- rtl/wfr_pkg.sv -----
// shared types, codes and helpers of the websocket frame receiver
`default_nettype none

package wfr_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR1RSV = 3'd2,
        PH_EXTHI   = 3'd3,
        PH_EXTLO   = 3'd4,
        PH_KEY     = 3'd5,
        PH_PASS    = 3'd6,
        PH_REJECT  = 3'd7
    } wfr_phase_t;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [1:0] KIND_MSG   = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [1:0] REASON_NORMAL   = 2'd0;
    localparam logic [1:0] REASON_PROTOCOL = 2'd1;
    localparam logic [1:0] REASON_DATATYPE = 2'd2;
    localparam logic [1:0] REASON_TOOBIG   = 2'd3;

    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;
    localparam logic [15:0] PING_MAX  = 16'd125;
    localparam logic [1:0] KEY_LAST   = 2'd3;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic       data_valid;
        logic [7:0] raw_byte;
        logic [7:0] key_byte;
        logic       end_of_run;
        logic [1:0] close_reason;
    } wfr_item_t;

    function automatic logic [1:0] reject_reason(input logic [3:0] op);
        logic [1:0] r;
        unique case (op)
            OP_TEXT:  r = REASON_DATATYPE;
            OP_CLOSE: r = REASON_NORMAL;
            OP_PING:  r = REASON_TOOBIG;
            default:  r = REASON_PROTOCOL;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] key_select(input logic [31:0] key, input logic [1:0] idx);
        logic [7:0] k;
        unique case (idx)
            2'd0:    k = key[31:24];
            2'd1:    k = key[23:16];
            2'd2:    k = key[15:8];
            default: k = key[7:0];
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/wfr_front.sv -----
// header parser: classifies each received byte and queues result items
`default_nettype none

module wfr_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       rx_byte,
    output logic                  push,
    output wfr_pkg::wfr_item_t    push_item
);

    wfr_pkg::wfr_phase_t phase_reg, phase_next;
    logic        final_reg, final_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [15:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  kidx_reg, kidx_next;
    logic        closed_reg, closed_next;
    logic        passes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wfr_pkg::PH_HDR0;
            final_reg  <= 1'b0;
            opcode_reg <= 4'h0;
            remain_reg <= 16'h0000;
            key_reg    <= 32'h0000_0000;
            kidx_reg   <= 2'd0;
            closed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            final_reg  <= final_next;
            opcode_reg <= opcode_next;
            remain_reg <= remain_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
            closed_reg <= closed_next;
        end
    end

    assign passes = (opcode_reg == wfr_pkg::OP_CONT) || (opcode_reg == wfr_pkg::OP_BINARY)
                 || (opcode_reg == wfr_pkg::OP_PONG)
                 || ((opcode_reg == wfr_pkg::OP_PING) && (remain_reg <= wfr_pkg::PING_MAX));

    always_comb
    begin
        phase_next  = phase_reg;
        final_next  = final_reg;
        opcode_next = opcode_reg;
        remain_next = remain_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        closed_next = closed_reg;
        push        = 1'b0;
        push_item   = '0;
        if (accept && !closed_reg)
        begin
            unique case (phase_reg) inside
                wfr_pkg::PH_HDR0:
                begin
                    final_next  = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    phase_next  = (|rx_byte[6:4]) ? wfr_pkg::PH_HDR1RSV : wfr_pkg::PH_HDR1;
                end
                wfr_pkg::PH_HDR1, wfr_pkg::PH_HDR1RSV:
                begin
                    if ((phase_reg == wfr_pkg::PH_HDR1RSV) || !rx_byte[7])
                    begin
                        closed_next            = 1'b1;
                        phase_next             = wfr_pkg::PH_HDR0;
                        push                   = 1'b1;
                        push_item.kind         = wfr_pkg::KIND_CLOSE;
                        push_item.close_reason = wfr_pkg::REASON_PROTOCOL;
                    end
                    else if (rx_byte[6:0] == wfr_pkg::LEN_EXT64)
                    begin
                        closed_next            = 1'b1;
                        phase_next             = wfr_pkg::PH_HDR0;
                        push                   = 1'b1;
                        push_item.kind         = wfr_pkg::KIND_CLOSE;
                        push_item.close_reason = wfr_pkg::REASON_TOOBIG;
                    end
                    else if (rx_byte[6:0] == wfr_pkg::LEN_EXT16)
                    begin
                        phase_next = wfr_pkg::PH_EXTHI;
                    end
                    else
                    begin
                        remain_next = {9'd0, rx_byte[6:0]};
                        kidx_next   = 2'd0;
                        phase_next  = wfr_pkg::PH_KEY;
                    end
                end
                wfr_pkg::PH_EXTHI:
                begin
                    remain_next = {rx_byte, 8'h00};
                    phase_next  = wfr_pkg::PH_EXTLO;
                end
                wfr_pkg::PH_EXTLO:
                begin
                    remain_next = {remain_reg[15:8], rx_byte};
                    kidx_next   = 2'd0;
                    phase_next  = wfr_pkg::PH_KEY;
                end
                wfr_pkg::PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (kidx_reg != wfr_pkg::KEY_LAST)
                    begin
                        kidx_next = kidx_reg + 2'd1;
                    end
                    else
                    begin
                        kidx_next = 2'd0;
                        if (!passes)
                        begin
                            if (remain_reg == 16'h0000)
                            begin
                                closed_next            = 1'b1;
                                phase_next             = wfr_pkg::PH_HDR0;
                                push                   = 1'b1;
                                push_item.kind         = wfr_pkg::KIND_CLOSE;
                                push_item.close_reason = wfr_pkg::reject_reason(opcode_reg);
                            end
                            else
                            begin
                                phase_next = wfr_pkg::PH_REJECT;
                            end
                        end
                        else if (remain_reg != 16'h0000)
                        begin
                            phase_next = wfr_pkg::PH_PASS;
                        end
                        else
                        begin
                            phase_next = wfr_pkg::PH_HDR0;
                            if (opcode_reg == wfr_pkg::OP_PING)
                            begin
                                push                 = 1'b1;
                                push_item.kind       = wfr_pkg::KIND_PING;
                                push_item.end_of_run = 1'b1;
                            end
                            else if ((opcode_reg != wfr_pkg::OP_PONG) && final_reg)
                            begin
                                push                 = 1'b1;
                                push_item.kind       = wfr_pkg::KIND_MSG;
                                push_item.end_of_run = 1'b1;
                            end
                        end
                    end
                end
                wfr_pkg::PH_PASS:
                begin
                    kidx_next   = kidx_reg + 2'd1;
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1)
                    begin
                        phase_next = wfr_pkg::PH_HDR0;
                    end
                    if (opcode_reg != wfr_pkg::OP_PONG)
                    begin
                        push                 = 1'b1;
                        push_item.data_valid = 1'b1;
                        push_item.raw_byte   = rx_byte;
                        push_item.key_byte   = wfr_pkg::key_select(key_reg, kidx_reg);
                        if (opcode_reg == wfr_pkg::OP_PING)
                        begin
                            push_item.kind       = wfr_pkg::KIND_PING;
                            push_item.end_of_run = (remain_reg == 16'd1);
                        end
                        else
                        begin
                            push_item.kind       = wfr_pkg::KIND_MSG;
                            push_item.end_of_run = (remain_reg == 16'd1) && final_reg;
                        end
                    end
                end
                default:
                begin
                    remain_next = remain_reg - 16'd1;
                    if (remain_reg == 16'd1)
                    begin
                        closed_next            = 1'b1;
                        phase_next             = wfr_pkg::PH_HDR0;
                        push                   = 1'b1;
                        push_item.kind         = wfr_pkg::KIND_CLOSE;
                        push_item.close_reason = wfr_pkg::reject_reason(opcode_reg);
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wfr_queue.sv -----
// short item queue between the parser and the output stage
`default_nettype none

module wfr_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire wfr_pkg::wfr_item_t push_item,
    input  wire logic             pop,
    output logic                  full,
    output logic                  nonempty,
    output wfr_pkg::wfr_item_t    head_item
);

    wfr_pkg::wfr_item_t mem [wfr_pkg::QDEPTH];
    logic [wfr_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [wfr_pkg::QCNT_W-1:0] count_reg;
    logic do_push, do_pop;

    assign full      = (count_reg == wfr_pkg::QCNT_W'(wfr_pkg::QDEPTH));
    assign nonempty  = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && nonempty;
    assign head_item = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wfr_back.sv -----
// output stage: unmasks queued items into the result register
`default_nettype none

module wfr_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire wfr_pkg::wfr_item_t head_item,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              out_kind,
    output logic                    data_valid,
    output logic [7:0]              payload_byte,
    output logic                    end_of_run,
    output logic [1:0]              close_reason
);

    logic       valid_reg;
    logic [1:0] kind_reg;
    logic       dvalid_reg;
    logic [7:0] byte_reg;
    logic       eor_reg;
    logic [1:0] reason_reg;

    assign pop = head_valid && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg   <= head_item.kind;
            dvalid_reg <= head_item.data_valid;
            byte_reg   <= head_item.raw_byte ^ head_item.key_byte;
            eor_reg    <= head_item.end_of_run;
            reason_reg <= head_item.close_reason;
        end
    end

    assign out_valid    = valid_reg;
    assign out_kind     = kind_reg;
    assign data_valid   = dvalid_reg;
    assign payload_byte = byte_reg;
    assign end_of_run   = eor_reg;
    assign close_reason = reason_reg;

endmodule

`default_nettype wire

// ----- rtl/websocket_frame_receiver_core.sv -----
// top level of the websocket frame receiver: parser, queue and output stage
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_ready  | rx_byte
//   output   | out_valid / out_ready| out_kind data_valid payload_byte end_of_run
//            |                      | close_reason
//
// one byte is taken per cycle while the queue is not full; a byte's result
// passes through the four-entry queue and then the output register
// reset returns the parser to header byte 0 with the link open
// in_ready drops only while the queue is full; a stalled output fills
// the queue, it never blocks the parser otherwise
`default_nettype none

module websocket_frame_receiver_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      out_kind,
    output logic            data_valid,
    output logic [7:0]      payload_byte,
    output logic            end_of_run,
    output logic [1:0]      close_reason
);

    logic               accept;
    logic               push;
    wfr_pkg::wfr_item_t push_item;
    logic               full;
    logic               nonempty;
    logic               pop;
    wfr_pkg::wfr_item_t head_item;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    wfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_item (push_item)
    );

    wfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (full),
        .nonempty  (nonempty),
        .head_item (head_item)
    );

    wfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (nonempty),
        .head_item    (head_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_kind     (out_kind),
        .data_valid   (data_valid),
        .payload_byte (payload_byte),
        .end_of_run   (end_of_run),
        .close_reason (close_reason)
    );

endmodule

`default_nettype wire
